// File: rtl/core/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the receive descriptor completion core:
// control word bit positions, checksum verdict codes and the decode record.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Control word field positions.
  localparam int unsigned LenMsb      = 13;
  localparam int unsigned TcpFailBit  = 14;
  localparam int unsigned UdpFailBit  = 15;
  localparam int unsigned IpFailBit   = 16;
  localparam int unsigned ProtoLsb    = 17;
  localparam int unsigned ProtoMsb    = 18;
  localparam int unsigned ErrSumBit   = 21;
  localparam int unsigned FifoOvfBit  = 23;
  localparam int unsigned LastSegBit  = 28;
  localparam int unsigned FirstSegBit = 29;
  localparam int unsigned DevOwnBit   = 31;

  localparam int unsigned CtlW  = 32;
  localparam int unsigned LenW  = 14;
  localparam int unsigned CsumW = 3;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CntW  = 32;

  // Protocol identifier codes.
  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_TCP  = 2'd1;
  localparam logic [1:0] PROTO_UDP  = 2'd2;
  localparam logic [1:0] PROTO_IP   = 2'd3;

  // Checksum verdict codes.
  localparam logic [CsumW-1:0] CSUM_NONE    = 3'd0;
  localparam logic [CsumW-1:0] CSUM_TCP_OK  = 3'd1;
  localparam logic [CsumW-1:0] CSUM_UDP_OK  = 3'd2;
  localparam logic [CsumW-1:0] CSUM_IP_OK   = 3'd3;
  localparam logic [CsumW-1:0] CSUM_TCP_BAD = 3'd4;
  localparam logic [CsumW-1:0] CSUM_UDP_BAD = 3'd5;
  localparam logic [CsumW-1:0] CSUM_IP_BAD  = 3'd6;

  localparam logic [LenW-1:0] CRC_BYTES = 14'd4;

  // Everything the decoder extracts from one control word.
  typedef struct packed {
    logic            dev_own;
    logic            deliver;
    logic [LenW-1:0] frame_len;
    logic [CsumW-1:0] csum;
    logic            fifo_ovf;
    logic            tcp_inc;
    logic            udp_inc;
    logic            ip_inc;
    logic            ovf_inc;
  } rdc_decode_t;

endpackage

// File: rtl/core/rdc_decode.sv
// ----------------------------------------------------------------------------
// rdc_decode
// Combinational classification of one receive descriptor control word.
// ----------------------------------------------------------------------------
module rdc_decode
  import rdc_pkg::*;
(
  input  logic [CtlW-1:0] ctl_i,
  output rdc_decode_t     dec_o
);

  logic            single_good;
  logic [LenW-1:0] raw_len;
  logic [1:0]      proto;

  assign raw_len = ctl_i[LenMsb:0];
  assign proto   = ctl_i[ProtoMsb:ProtoLsb];

  // A frame is handed up only when host owned, single segment and error free.
  assign single_good = !ctl_i[DevOwnBit] && ctl_i[FirstSegBit] && ctl_i[LastSegBit]
                       && !ctl_i[ErrSumBit];

  always_comb begin
    dec_o          = '0;
    dec_o.dev_own  = ctl_i[DevOwnBit];
    dec_o.deliver  = single_good;
    if (single_good) begin
      // Strip the CRC bytes, saturating at zero.
      dec_o.frame_len = (raw_len >= CRC_BYTES) ? (raw_len - CRC_BYTES) : '0;
      dec_o.fifo_ovf  = ctl_i[FifoOvfBit];
      dec_o.ovf_inc   = ctl_i[FifoOvfBit];
      unique case (proto)
        PROTO_TCP: begin
          dec_o.csum    = ctl_i[TcpFailBit] ? CSUM_TCP_BAD : CSUM_TCP_OK;
          dec_o.tcp_inc = ctl_i[TcpFailBit];
        end
        PROTO_UDP: begin
          dec_o.csum    = ctl_i[UdpFailBit] ? CSUM_UDP_BAD : CSUM_UDP_OK;
          dec_o.udp_inc = ctl_i[UdpFailBit];
        end
        PROTO_IP: begin
          dec_o.csum   = ctl_i[IpFailBit] ? CSUM_IP_BAD : CSUM_IP_OK;
          dec_o.ip_inc = ctl_i[IpFailBit];
        end
        default: begin
          dec_o.csum = CSUM_NONE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/rx_descriptor_completion_core.sv
// ----------------------------------------------------------------------------
// rx_descriptor_completion_core
// Result: registered, shown on the output in the cycle after it is accepted.
// Throughput: one item per cycle unless the output stalls; the result register
// frees in the same cycle its item is taken, so input and output overlap fully.
// Reset: asynchronous, active low; head 0, outstanding RING_DEPTH-1,
// all counters 0, output empty.
// ----------------------------------------------------------------------------
module rx_descriptor_completion_core
  import rdc_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CtlW-1:0]  descriptor_control_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             consumed_o,
  output logic [SlotW-1:0] slot_index_o,
  output logic             deliver_o,
  output logic [LenW-1:0]  frame_length_o,
  output logic [CsumW-1:0] checksum_status_o,
  output logic             fifo_overflow_o,
  output logic             replenish_request_o,
  output logic [CntW-1:0]  tcp_fail_total_o,
  output logic [CntW-1:0]  udp_fail_total_o,
  output logic [CntW-1:0]  ip_fail_total_o,
  output logic [CntW-1:0]  overflow_total_o
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned PadW = (IdxW > SlotW) ? IdxW : SlotW;
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(RING_DEPTH - 1);
  localparam logic [IdxW-1:0] FullOut  = IdxW'(RING_DEPTH - 1);
  localparam logic [IdxW-1:0] HalfRing = IdxW'(RING_DEPTH / 2);

  rdc_decode_t     dec;
  logic            accept;
  logic [PadW-1:0] head_pad;

  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] outst_q, outst_d;
  logic [CntW-1:0] tcp_cnt_q, tcp_cnt_d;
  logic [CntW-1:0] udp_cnt_q, udp_cnt_d;
  logic [CntW-1:0] ip_cnt_q, ip_cnt_d;
  logic [CntW-1:0] ovf_cnt_q, ovf_cnt_d;
  logic            repl_d;

  logic             out_valid_q;
  logic             consumed_q;
  logic [SlotW-1:0] slot_q;
  logic             deliver_q;
  logic [LenW-1:0]  flen_q;
  logic [CsumW-1:0] csum_q;
  logic             fovf_q;
  logic             repl_q;

  rdc_decode u_decode (
    .ctl_i (descriptor_control_i),
    .dec_o (dec)
  );

  // The result register takes a new item whenever it is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign head_pad   = PadW'(head_q);

  // Ring bookkeeping and counter updates for the item at the input.
  always_comb begin
    head_d    = head_q;
    outst_d   = outst_q;
    repl_d    = 1'b0;
    tcp_cnt_d = tcp_cnt_q + CntW'(dec.tcp_inc);
    udp_cnt_d = udp_cnt_q + CntW'(dec.udp_inc);
    ip_cnt_d  = ip_cnt_q + CntW'(dec.ip_inc);
    ovf_cnt_d = ovf_cnt_q + CntW'(dec.ovf_inc);
    if (dec.dev_own) begin
      // Batch end: ask for a refill when the ring ran below half.
      if (outst_q < HalfRing) begin
        repl_d  = 1'b1;
        outst_d = FullOut;
      end
    end else begin
      if (outst_q != '0) begin
        outst_d = outst_q - 1'b1;
      end
      head_d = (head_q == LastIdx) ? '0 : head_q + 1'b1;
    end
  end

  // Ring state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      outst_q   <= FullOut;
      tcp_cnt_q <= '0;
      udp_cnt_q <= '0;
      ip_cnt_q  <= '0;
      ovf_cnt_q <= '0;
    end else if (accept) begin
      head_q    <= head_d;
      outst_q   <= outst_d;
      tcp_cnt_q <= tcp_cnt_d;
      udp_cnt_q <= udp_cnt_d;
      ip_cnt_q  <= ip_cnt_d;
      ovf_cnt_q <= ovf_cnt_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      consumed_q <= !dec.dev_own;
      slot_q     <= head_pad[SlotW-1:0];
      deliver_q  <= dec.deliver;
      flen_q     <= dec.frame_len;
      csum_q     <= dec.csum;
      fovf_q     <= dec.fifo_ovf;
      repl_q     <= repl_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign consumed_o          = consumed_q;
  assign slot_index_o        = slot_q;
  assign deliver_o           = deliver_q;
  assign frame_length_o      = flen_q;
  assign checksum_status_o   = csum_q;
  assign fifo_overflow_o     = fovf_q;
  assign replenish_request_o = repl_q;
  assign tcp_fail_total_o    = tcp_cnt_q;
  assign udp_fail_total_o    = udp_cnt_q;
  assign ip_fail_total_o     = ip_cnt_q;
  assign overflow_total_o    = ovf_cnt_q;

endmodule

// File: rtl/core/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks for the receive descriptor completion core, bound to
// the top level.
// ----------------------------------------------------------------------------
module rdc_checker
  import rdc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CtlW-1:0]  descriptor_control_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             consumed_o,
  input logic [SlotW-1:0] slot_index_o,
  input logic             deliver_o,
  input logic [LenW-1:0]  frame_length_o,
  input logic [CsumW-1:0] checksum_status_o,
  input logic             fifo_overflow_o,
  input logic             replenish_request_o,
  input logic [CntW-1:0]  tcp_fail_total_o,
  input logic [CntW-1:0]  udp_fail_total_o,
  input logic [CntW-1:0]  ip_fail_total_o,
  input logic [CntW-1:0]  overflow_total_o
);

  // A stalled result holds its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_index_o)
      && $stable(consumed_o) && $stable(tcp_fail_total_o))
    else $error("stalled result changed");

  // A refill request only ends a batch, never on a consumed slot.
  a_repl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replenish_request_o |-> !consumed_o && !deliver_o)
    else $error("replenish on consumed slot");

  // Only a delivered frame carries length, verdict or overflow.
  a_nodeliver_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !deliver_o |-> frame_length_o == '0
      && checksum_status_o == CSUM_NONE && !fifo_overflow_o)
    else $error("undelivered result carries frame data");

  // Delivery implies the slot was consumed.
  a_deliver_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_o |-> consumed_o)
    else $error("delivered a device-owned slot");

  // The input stalls only while a result is waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

endmodule

bind rx_descriptor_completion_core rdc_checker u_rdc_checker (.*);

// File: tb/rx_descriptor_completion_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_descriptor_completion_core_tb
// Self-checking testbench for the receive descriptor completion core. A short
// directed pass covers length edges, every checksum verdict and the frames
// that are dropped. A long random pass then feeds batches of host-owned
// descriptors ended by device-owned ones, so that head wrap, replenish and
// outstanding underflow are all reached. An internal ring model predicts
// each result, and a monitor compares results in order. Both handshakes see
// random gaps and backpressure.
// ----------------------------------------------------------------------------
module rx_descriptor_completion_core_tb
  import rdc_pkg::*;
;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RANDOM_ITEMS = 1350;

  // Control word masks built from the package bit positions.
  localparam logic [CtlW-1:0] DEV_OWNED = 32'd1 << DevOwnBit;
  localparam logic [CtlW-1:0] FIRST_SEG = 32'd1 << FirstSegBit;
  localparam logic [CtlW-1:0] LAST_SEG  = 32'd1 << LastSegBit;
  localparam logic [CtlW-1:0] ERR_SUM   = 32'd1 << ErrSumBit;
  localparam logic [CtlW-1:0] FIFO_OVF  = 32'd1 << FifoOvfBit;
  localparam logic [CtlW-1:0] TCP_FAIL  = 32'd1 << TcpFailBit;
  localparam logic [CtlW-1:0] UDP_FAIL  = 32'd1 << UdpFailBit;
  localparam logic [CtlW-1:0] IP_FAIL   = 32'd1 << IpFailBit;

  // One result item as the core reports it.
  typedef struct packed {
    logic             consumed;
    logic [SlotW-1:0] slot;
    logic             deliver;
    logic [LenW-1:0]  frame_len;
    logic [CsumW-1:0] csum;
    logic             fifo_ovf;
    logic             replenish;
    logic [CntW-1:0]  tcp_total;
    logic [CntW-1:0]  udp_total;
    logic [CntW-1:0]  ip_total;
    logic [CntW-1:0]  ovf_total;
  } completion_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [CtlW-1:0] desc_ctl = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  completion_t     seen;

  // Ring model state, starting at its reset values.
  int unsigned     ring_head = 0;
  int unsigned     ring_outstanding = RING_DEPTH - 1;
  logic [CntW-1:0] tcp_fail_cnt = '0;
  logic [CntW-1:0] udp_fail_cnt = '0;
  logic [CntW-1:0] ip_fail_cnt = '0;
  logic [CntW-1:0] ovf_cnt = '0;

  completion_t     completions_due[$];
  int unsigned     mismatches = 0;
  int unsigned     random_sent = 0;
  bit              tx_throttle = 1'b1;
  bit              rx_throttle = 1'b1;

  rx_descriptor_completion_core #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .descriptor_control_i(desc_ctl),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .consumed_o          (seen.consumed),
    .slot_index_o        (seen.slot),
    .deliver_o           (seen.deliver),
    .frame_length_o      (seen.frame_len),
    .checksum_status_o   (seen.csum),
    .fifo_overflow_o     (seen.fifo_ovf),
    .replenish_request_o (seen.replenish),
    .tcp_fail_total_o    (seen.tcp_total),
    .udp_fail_total_o    (seen.udp_total),
    .ip_fail_total_o     (seen.ip_total),
    .overflow_total_o    (seen.ovf_total)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Examine the descriptor at the head and advance the ring model.
  function automatic completion_t retire_descriptor(input logic [CtlW-1:0] ctl);
    completion_t     c;
    logic [1:0]      proto;
    logic [LenW-1:0] len;
    c = '0;
    c.slot = ring_head[SlotW-1:0];
    proto = ctl[ProtoMsb:ProtoLsb];
    len = ctl[LenMsb:0];
    if (ctl[DevOwnBit]) begin
      // The batch ends here; refill when less than half is outstanding.
      if (ring_outstanding < RING_DEPTH / 2) begin
        c.replenish = 1'b1;
        ring_outstanding = RING_DEPTH - 1;
      end
    end else begin
      c.consumed = 1'b1;
      if (ctl[FirstSegBit] && ctl[LastSegBit] && !ctl[ErrSumBit]) begin
        c.deliver = 1'b1;
        c.frame_len = (len >= CRC_BYTES) ? len - CRC_BYTES : '0;
        if (ctl[FifoOvfBit]) begin
          c.fifo_ovf = 1'b1;
          ovf_cnt = ovf_cnt + 1'b1;
        end
        case (proto)
          PROTO_TCP: begin
            if (ctl[TcpFailBit]) begin
              c.csum = CSUM_TCP_BAD;
              tcp_fail_cnt = tcp_fail_cnt + 1'b1;
            end else begin
              c.csum = CSUM_TCP_OK;
            end
          end
          PROTO_UDP: begin
            if (ctl[UdpFailBit]) begin
              c.csum = CSUM_UDP_BAD;
              udp_fail_cnt = udp_fail_cnt + 1'b1;
            end else begin
              c.csum = CSUM_UDP_OK;
            end
          end
          PROTO_IP: begin
            if (ctl[IpFailBit]) begin
              c.csum = CSUM_IP_BAD;
              ip_fail_cnt = ip_fail_cnt + 1'b1;
            end else begin
              c.csum = CSUM_IP_OK;
            end
          end
          default: begin
            c.csum = CSUM_NONE;
          end
        endcase
      end
      // The outstanding count does not go below zero.
      if (ring_outstanding != 0) begin
        ring_outstanding = ring_outstanding - 1;
      end
      ring_head = (ring_head + 1 >= RING_DEPTH) ? 0 : ring_head + 1;
    end
    c.tcp_total = tcp_fail_cnt;
    c.udp_total = udp_fail_cnt;
    c.ip_total = ip_fail_cnt;
    c.ovf_total = ovf_cnt;
    return c;
  endfunction

  // Idle cycles before the next item: mostly none, some short, a few long.
  function automatic int unsigned input_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!tx_throttle || roll < 65) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Drive one item, wait until it is taken, and record its expected result.
  task automatic push_descriptor(input logic [CtlW-1:0] ctl);
    int unsigned gap;
    gap = input_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      desc_ctl <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    desc_ctl <= ctl;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    completions_due.push_back(retire_descriptor(ctl));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
    desc_ctl <= '0;
  endtask

  // A complete, error-free single-segment frame.
  function automatic logic [CtlW-1:0] good_frame(input logic [LenW-1:0] len,
                                                 input logic [1:0] proto,
                                                 input logic [CtlW-1:0] extra);
    logic [CtlW-1:0] w;
    w = FIRST_SEG | LAST_SEG | extra;
    w[LenMsb:0] = len;
    w[ProtoMsb:ProtoLsb] = proto;
    return w;
  endfunction

  // Host-owned word with random content, mostly a deliverable frame.
  function automatic logic [CtlW-1:0] random_frame();
    logic [CtlW-1:0] w;
    int unsigned     roll;
    w = $urandom;
    w[DevOwnBit] = 1'b0;
    if ($urandom_range(0, 99) < 75) begin
      w = (w | FIRST_SEG | LAST_SEG) & ~ERR_SUM;
    end
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      w[LenMsb:0] = LenW'($urandom_range(0, 8));
    end else if (roll < 25) begin
      w[LenMsb:0] = LenW'($urandom_range(16376, 16383));
    end
    return w;
  endfunction

  task automatic check_field(input string field, input logic [CntW-1:0] want,
                             input logic [CntW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Result monitor: each accepted result against the oldest expectation.
  initial begin : result_monitor
    completion_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (completions_due.size() == 0) begin
          $error("result arrived with no item outstanding");
          mismatches++;
        end else begin
          want = completions_due.pop_front();
          check_field("consumed", CntW'(want.consumed), CntW'(seen.consumed));
          check_field("slot_index", CntW'(want.slot), CntW'(seen.slot));
          check_field("deliver", CntW'(want.deliver), CntW'(seen.deliver));
          check_field("frame_length", CntW'(want.frame_len), CntW'(seen.frame_len));
          check_field("checksum_status", CntW'(want.csum), CntW'(seen.csum));
          check_field("fifo_overflow", CntW'(want.fifo_ovf), CntW'(seen.fifo_ovf));
          check_field("replenish_request", CntW'(want.replenish),
                      CntW'(seen.replenish));
          check_field("tcp_fail_total", want.tcp_total, seen.tcp_total);
          check_field("udp_fail_total", want.udp_total, seen.udp_total);
          check_field("ip_fail_total", want.ip_total, seen.ip_total);
          check_field("overflow_total", want.ovf_total, seen.ovf_total);
        end
      end
    end
  end

  // Output backpressure: stall bursts, mostly short and a few long.
  initial begin : rx_backpressure
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold == 0 && rx_throttle && $urandom_range(0, 99) < 20) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      end
      out_stall <= (hold != 0);
      if (hold != 0) begin
        hold--;
      end
    end
  end

  // A fresh ring has plenty outstanding, so device-owned words only end batches.
  task automatic test_idle_ring();
    push_descriptor(DEV_OWNED);
    push_descriptor('1);
  endtask

  // Lengths around the CRC trim and the largest length.
  task automatic test_frame_lengths();
    push_descriptor(good_frame(14'd0, PROTO_NONE, '0));
    push_descriptor(good_frame(14'd1, PROTO_NONE, '0));
    push_descriptor(good_frame(14'd3, PROTO_NONE, '0));
    push_descriptor(good_frame(14'd4, PROTO_NONE, '0));
    push_descriptor(good_frame(14'd5, PROTO_NONE, '0));
    push_descriptor(good_frame(14'h3FFF, PROTO_NONE, '0));
  endtask

  // Every checksum verdict, plus fail bits that belong to another protocol.
  task automatic test_checksum_verdicts();
    push_descriptor(good_frame(14'd64, PROTO_TCP, '0));
    push_descriptor(good_frame(14'd64, PROTO_TCP, TCP_FAIL));
    push_descriptor(good_frame(14'd128, PROTO_UDP, '0));
    push_descriptor(good_frame(14'd128, PROTO_UDP, UDP_FAIL));
    push_descriptor(good_frame(14'd1514, PROTO_IP, '0));
    push_descriptor(good_frame(14'd1514, PROTO_IP, IP_FAIL));
    push_descriptor(good_frame(14'd60, PROTO_NONE, TCP_FAIL | UDP_FAIL | IP_FAIL));
    push_descriptor(good_frame(14'd60, PROTO_TCP, UDP_FAIL | IP_FAIL));
  endtask

  // Fragments and errored frames are consumed but not delivered.
  task automatic test_undelivered_frames();
    push_descriptor(FIRST_SEG | 32'd100);
    push_descriptor(LAST_SEG | 32'd100);
    push_descriptor(32'd100 | TCP_FAIL);
    push_descriptor(good_frame(14'd200, PROTO_UDP, ERR_SUM | UDP_FAIL));
    push_descriptor(good_frame(14'd200, PROTO_TCP, ERR_SUM | FIFO_OVF | TCP_FAIL));
  endtask

  task automatic test_fifo_overflow();
    push_descriptor(good_frame(14'd300, PROTO_IP, FIFO_OVF | IP_FAIL));
    push_descriptor(good_frame(14'd2, PROTO_NONE, FIFO_OVF));
  endtask

  // Batches of host-owned words closed by device-owned ones. Long batches
  // wrap the head and drain the outstanding count to zero.
  task automatic test_ring_batches();
    int unsigned run;
    int unsigned roll;
    while (random_sent < RANDOM_ITEMS) begin
      tx_throttle = ($urandom_range(0, 3) != 0);
      rx_throttle = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        run = $urandom_range(1, 20);
      end else if (roll < 90) begin
        run = $urandom_range(21, 40);
      end else begin
        run = $urandom_range(60, 90);
      end
      repeat (run) begin
        if ($urandom_range(0, 99) < 5) begin
          push_descriptor($urandom);
        end else begin
          push_descriptor(random_frame());
        end
        random_sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        push_descriptor($urandom | DEV_OWNED);
        random_sent++;
      end
    end
  endtask

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ring();
    test_frame_lengths();
    test_checksum_verdicts();
    test_undelivered_frames();
    test_fifo_overflow();
    test_ring_batches();
    release_input();
    rx_throttle = 1'b0;
    while (completions_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/core/rdc_pkg.sv
rtl/core/rdc_decode.sv
rtl/core/rx_descriptor_completion_core.sv
rtl/core/rdc_checker.sv
tb/rx_descriptor_completion_core_tb.sv
